### rtl/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants of the sample voice mixer
// Sizes, operation codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package svm_pkg;

   localparam int VOICE_COUNT = 8;
   localparam int CLIP_DEPTH  = 4096;
   localparam int CHANNEL_MAX = 2;

   localparam int CLIP_AW = $clog2(CLIP_DEPTH);
   localparam int LEN_W   = CLIP_AW + 1;
   localparam int OFF_W   = CLIP_AW;
   localparam int VIDX_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int VCNT_W  = $clog2(VOICE_COUNT + 1);
   localparam int PROD_W  = 33;
   localparam int ACC_W   = PROD_W + VCNT_W + 1;

   localparam logic [15:0] UNITY_GAIN = 16'h8000;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_PLAY = 2'd1,
      OP_MIX  = 2'd2
   } svm_op_type;

   typedef enum logic [1:0] {
      REG_CLIP_CHANNELS = 2'd0,
      REG_OUT_CHANNELS  = 2'd1,
      REG_MAX_VOICES    = 2'd2
   } svm_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_PLAY,
      ST_PASS,
      ST_ZERO,
      ST_SCAN,
      ST_DRAIN,
      ST_MIXEND,
      ST_WAIT
   } svm_state_type;

   typedef struct packed {
      logic [1:0] clip_channels;
      logic [1:0] out_channels;
      logic [3:0] max_voices;
   } svm_cfg_type;

   typedef struct packed {
      logic capture;
      logic do_load;
      logic do_play;
      logic do_pass;
      logic do_zero;
      logic scan;
      logic do_mix_end;
   } svm_cmd_type;

   typedef struct packed {
      logic bypass;
      logic scan_last;
      logic pipe_idle;
   } svm_status_type;

   function automatic logic [1:0] eff_channels(input logic [1:0] c);
      logic [1:0] r;
      r = c;
      if (c == 2'd0) r = 2'd1;
      if (c > 2'(CHANNEL_MAX)) r = 2'(CHANNEL_MAX);
      return r;
   endfunction

endpackage

### rtl/svm_ctrl.sv
// ----------------------------------------------------------------------------
// svm_ctrl: sequencing of the sample voice mixer
// Decodes each accepted beat and steps the datapath through load, play, zero,
// pass-through or voice scan mix, then hands the result to the output register.
// ----------------------------------------------------------------------------
module svm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic [1:0]              req_op,
   output logic                    req_tready,
   input  logic                    out_free,
   output logic                    out_load,
   input  svm_pkg::svm_status_type status,
   output svm_pkg::svm_cmd_type    cmd
);
   import svm_pkg::*;

   svm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               case (req_op)
                  OP_LOAD: state_in = ST_LOAD;
                  OP_PLAY: state_in = ST_PLAY;
                  OP_MIX:  state_in = status.bypass ? ST_PASS : ST_SCAN;
                  default: state_in = ST_ZERO;
               endcase
            end
         end
         ST_LOAD: begin
            cmd.do_load = 1'b1;
            state_in    = ST_WAIT;
         end
         ST_PLAY: begin
            cmd.do_play = 1'b1;
            state_in    = ST_WAIT;
         end
         ST_PASS: begin
            cmd.do_pass = 1'b1;
            state_in    = ST_WAIT;
         end
         ST_ZERO: begin
            cmd.do_zero = 1'b1;
            state_in    = ST_WAIT;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (status.pipe_idle) state_in = ST_MIXEND;
         end
         ST_MIXEND: begin
            cmd.do_mix_end = 1'b1;
            state_in       = ST_WAIT;
         end
         ST_WAIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### rtl/svm_dpath.sv
// ----------------------------------------------------------------------------
// svm_dpath: clip memory, voice pool and mix accumulator
// Voice scan pipeline: address, registered clip read, product, accumulate.
// ----------------------------------------------------------------------------
module svm_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  svm_pkg::svm_cmd_type    cmd,
   input  svm_pkg::svm_cfg_type    cfg,
   input  logic [15:0]             req_sample,
   input  logic [15:0]             req_gain,
   output svm_pkg::svm_status_type status,
   output logic [15:0]             res_mixed,
   output logic                    res_refused,
   output logic                    res_clipped
);
   import svm_pkg::*;

   logic signed [15:0] clip_mem [CLIP_DEPTH];
   logic signed [15:0] rd_data_ff;
   logic [CLIP_AW-1:0] rd_addr;

   logic [LEN_W-1:0]   clip_len_ff;
   logic               chan_pos_ff, chan_pos_in;

   logic [VOICE_COUNT-1:0] active_ff, active_in;
   logic [OFF_W-1:0]       offset_ff [VOICE_COUNT];
   logic [OFF_W-1:0]       offset_in [VOICE_COUNT];
   logic [15:0]            volume_ff [VOICE_COUNT];
   logic [15:0]            volume_in [VOICE_COUNT];

   logic [15:0]            sample_ff;
   logic [15:0]            gain_ff;

   logic [VIDX_W-1:0]      scan_idx_ff;
   logic                   s1_busy_ff, s1_hit_ff, s2_busy_ff;
   logic [15:0]            s1_vol_ff;
   logic signed [16:0]     s1_vol_s;
   logic signed [PROD_W-1:0] product_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   logic [15:0]            res_mixed_ff;
   logic                   res_refused_ff, res_clipped_ff;

   logic [1:0]             cc, oc;
   logic                   cc_is2;
   logic [LEN_W-1:0]       frames;
   logic                   pos_eff;
   logic                   frame_end;
   logic                   hit;
   logic [LEN_W-1:0]       addr_full;
   logic                   clip_full;

   logic [VCNT_W-1:0]      play_count;
   logic                   play_found;
   logic [VIDX_W-1:0]      play_slot;
   logic [7:0]             play_limit;
   logic                   play_ok;
   logic [15:0]            gain_sat;

   logic signed [ACC_W-1:0] round_sum;
   logic signed [ACC_W-1:0] round_q;

   // effective configuration
   assign cc        = eff_channels(cfg.clip_channels);
   assign oc        = eff_channels(cfg.out_channels);
   assign cc_is2    = (cc == 2'd2);
   assign frames    = cc_is2 ? (clip_len_ff >> 1) : clip_len_ff;
   assign pos_eff   = ({1'b0, chan_pos_ff} < cc) ? chan_pos_ff : ~cc_is2 ? 1'b0 : 1'b1;
   assign frame_end = (2'({1'b0, pos_eff}) + 2'd1) >= cc;
   assign clip_full = (clip_len_ff >= LEN_W'(CLIP_DEPTH));

   assign status.bypass    = (cc != oc) || (frames == '0);
   assign status.scan_last = (scan_idx_ff == VIDX_W'(VOICE_COUNT - 1));
   assign status.pipe_idle = !s1_busy_ff && !s2_busy_ff;

   // scan address
   assign hit       = active_ff[scan_idx_ff] && ({1'b0, offset_ff[scan_idx_ff]} < frames);
   assign addr_full = (cc_is2 ? {offset_ff[scan_idx_ff], 1'b0} : {1'b0, offset_ff[scan_idx_ff]})
                      + LEN_W'(pos_eff);
   assign rd_addr   = addr_full[CLIP_AW-1:0];

   // free slot search
   always_comb begin
      play_count = '0;
      play_found = 1'b0;
      play_slot  = '0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
         if (active_ff[v]) begin
            play_count = play_count + VCNT_W'(1);
         end else if (!play_found) begin
            play_found = 1'b1;
            play_slot  = VIDX_W'(v);
         end
      end
   end

   assign play_limit = (8'(cfg.max_voices) > 8'(VOICE_COUNT)) ? 8'(VOICE_COUNT)
                                                                : 8'(cfg.max_voices);
   assign play_ok    = play_found && (8'(play_count) < play_limit);
   assign gain_sat   = (gain_ff > UNITY_GAIN) ? UNITY_GAIN : gain_ff;

   // voice pool next state
   always_comb begin
      logic [OFF_W-1:0] nxt;
      nxt       = '0;
      active_in = active_ff;
      offset_in = offset_ff;
      volume_in = volume_ff;
      if (cmd.do_play && play_ok) begin
         active_in[play_slot] = 1'b1;
         offset_in[play_slot] = '0;
         volume_in[play_slot] = gain_sat;
      end
      if (cmd.scan && active_ff[scan_idx_ff] && !hit) begin
         active_in[scan_idx_ff] = 1'b0;
      end
      if (cmd.do_mix_end && frame_end) begin
         for (int v = 0; v < VOICE_COUNT; v++) begin
            if (active_ff[v]) begin
               nxt = offset_ff[v] + OFF_W'(1);
               if ((nxt == '0) || ({1'b0, nxt} >= frames)) begin
                  active_in[v] = 1'b0;
                  offset_in[v] = '0;
               end else begin
                  offset_in[v] = nxt;
               end
            end
         end
      end
   end

   always_comb begin
      chan_pos_in = chan_pos_ff;
      if (cmd.do_mix_end) begin
         chan_pos_in = frame_end ? 1'b0 : ~pos_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= '0;
         clip_len_ff <= '0;
         chan_pos_ff <= 1'b0;
         for (int v = 0; v < VOICE_COUNT; v++) begin
            offset_ff[v] <= '0;
            volume_ff[v] <= '0;
         end
      end else begin
         active_ff   <= active_in;
         offset_ff   <= offset_in;
         volume_ff   <= volume_in;
         chan_pos_ff <= chan_pos_in;
         if (cmd.do_load && !clip_full) clip_len_ff <= clip_len_ff + LEN_W'(1);
      end
   end

   // clip memory
   always_ff @(posedge clock) begin
      if (cmd.do_load && !clip_full) clip_mem[clip_len_ff[CLIP_AW-1:0]] <= sample_ff;
      if (cmd.scan) rd_data_ff <= clip_mem[rd_addr];
   end

   // scan pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_busy_ff  <= 1'b0;
         s2_busy_ff  <= 1'b0;
         scan_idx_ff <= '0;
      end else begin
         s1_busy_ff <= cmd.scan;
         s2_busy_ff <= s1_busy_ff;
         if (cmd.capture) begin
            scan_idx_ff <= '0;
         end else if (cmd.scan) begin
            scan_idx_ff <= scan_idx_ff + VIDX_W'(1);
         end
      end
   end

   assign s1_vol_s = $signed({1'b0, s1_vol_ff});

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_sample;
         gain_ff   <= req_gain;
      end
      if (cmd.scan) begin
         s1_hit_ff <= hit;
         s1_vol_ff <= volume_ff[scan_idx_ff];
      end
      if (s1_busy_ff) begin
         product_ff <= s1_hit_ff ? rd_data_ff * s1_vol_s : $signed(PROD_W'(0));
      end
      if (cmd.capture) begin
         acc_ff <= $signed({{(ACC_W-16){req_sample[15]}}, req_sample}) <<< 15;
      end else if (s2_busy_ff) begin
         acc_ff <= acc_ff + $signed({{(ACC_W-PROD_W){product_ff[PROD_W-1]}}, product_ff});
      end
   end

   // round half up, then saturate
   assign round_sum = acc_ff + ACC_W'(16384);
   assign round_q   = round_sum >>> 15;

   always_ff @(posedge clock) begin
      if (cmd.do_load) begin
         res_mixed_ff   <= '0;
         res_refused_ff <= clip_full;
         res_clipped_ff <= 1'b0;
      end else if (cmd.do_play) begin
         res_mixed_ff   <= '0;
         res_refused_ff <= !play_ok;
         res_clipped_ff <= 1'b0;
      end else if (cmd.do_pass) begin
         res_mixed_ff   <= sample_ff;
         res_refused_ff <= 1'b0;
         res_clipped_ff <= 1'b0;
      end else if (cmd.do_zero) begin
         res_mixed_ff   <= '0;
         res_refused_ff <= 1'b0;
         res_clipped_ff <= 1'b0;
      end else if (cmd.do_mix_end) begin
         res_refused_ff <= 1'b0;
         if (round_q > ACC_W'(32767)) begin
            res_mixed_ff   <= 16'h7FFF;
            res_clipped_ff <= 1'b1;
         end else if (round_q < -ACC_W'(32768)) begin
            res_mixed_ff   <= 16'h8000;
            res_clipped_ff <= 1'b1;
         end else begin
            res_mixed_ff   <= round_q[15:0];
            res_clipped_ff <= 1'b0;
         end
      end
   end

   assign res_mixed   = res_mixed_ff;
   assign res_refused = res_refused_ff;
   assign res_clipped = res_clipped_ff;

endmodule

### rtl/sample_voice_mixer_unit.sv
// ----------------------------------------------------------------------------
// Sequence: load, play and pass-through mix go from accept through their own
// state and a wait for the output register to the rsp beat; a full mix scans
// one voice per scan state, drains the clip read, product and accumulate stages,
// rounds, then loads the output register. The next beat waits for the result.
// Reset: synchronous, clears clip length, voice pool and channel position;
// registers return to 1, 1 and 8. Clip memory content is not cleared.
// ----------------------------------------------------------------------------
// sample_voice_mixer_unit: polyphonic clip playback mixer
// Stream in/out with an APB register port; controller plus datapath.
// ----------------------------------------------------------------------------
module sample_voice_mixer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] sample_value, [31:16] gain
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] mixed_sample
   output logic [1:0]  rsp_tuser,   // [0] refused, [1] clipped
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import svm_pkg::*;

   svm_cfg_type    cfg_ff;
   svm_cmd_type    cmd;
   svm_status_type status;
   logic           csr_wr;
   logic [15:0]    res_mixed;
   logic           res_refused, res_clipped;
   logic           out_load, out_free;
   logic           rsp_valid_ff;
   logic [15:0]    rsp_data_ff;
   logic [1:0]     rsp_user_ff;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clip_channels <= 2'd1;
         cfg_ff.out_channels  <= 2'd1;
         cfg_ff.max_voices    <= 4'd8;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_CLIP_CHANNELS: cfg_ff.clip_channels <= csr_pwdata[1:0];
            REG_OUT_CHANNELS:  cfg_ff.out_channels  <= csr_pwdata[1:0];
            REG_MAX_VOICES:    cfg_ff.max_voices    <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_CLIP_CHANNELS: csr_prdata = {30'd0, cfg_ff.clip_channels};
         REG_OUT_CHANNELS:  csr_prdata = {30'd0, cfg_ff.out_channels};
         REG_MAX_VOICES:    csr_prdata = {28'd0, cfg_ff.max_voices};
         default:           csr_prdata = '0;
      endcase
   end

   svm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .out_free   (out_free),
      .out_load   (out_load),
      .status     (status),
      .cmd        (cmd)
   );

   svm_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cfg         (cfg_ff),
      .req_sample  (req_tdata[15:0]),
      .req_gain    (req_tdata[31:16]),
      .status      (status),
      .res_mixed   (res_mixed),
      .res_refused (res_refused),
      .res_clipped (res_clipped)
   );

   // output register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= res_mixed;
         rsp_user_ff <= {res_clipped, res_refused};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
